// File: rtl/lmqb_pkg.sv
// ----------------------------------------------------------------------------
// lmqb_pkg
// Shared types and codes for the linked multi-queue buffer.
// ----------------------------------------------------------------------------
package lmqb_pkg;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_DUMP  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_ELEM    = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_PUSHED  = 3'd2,
    ST_FULL    = 3'd3,
    ST_CLEARED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_DUMP = 2'd2
  } state_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [3:0]         queue_sel;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] elem_value;
    logic               last;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;        // latch input item, start lookups
    logic    push;        // link new entry onto queue
    logic    clear;       // splice queue onto free chain
    logic    dump_start;  // issue reads at queue head
    logic    dump_next;   // advance walk to next entry
    logic    emit;        // load output register
    status_t status;
    logic    last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_t  op;
    logic q_ok;        // queue number in range
    logic q_live;      // queue in range and not empty
    logic pool_empty;
    logic final_elem;  // current dump element is the tail
    logic out_free;
  } sts_t;

endpackage

// File: rtl/lmqb_ctrl.sv
// ----------------------------------------------------------------------------
// lmqb_ctrl
// Sequencer: accepts one item, runs push/clear/dump, drives emit commands.
// ----------------------------------------------------------------------------
module lmqb_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  lmqb_pkg::sts_t sts,
  output lmqb_pkg::cmd_t cmd
);

  lmqb_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lmqb_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lmqb_pkg::S_IDLE: begin
        if (in_valid) state_nxt = lmqb_pkg::S_EXEC;
      end
      lmqb_pkg::S_EXEC: begin
        unique case (sts.op)
          lmqb_pkg::OP_DUMP: begin
            if (sts.q_live) state_nxt = lmqb_pkg::S_DUMP;
            else if (sts.out_free) state_nxt = lmqb_pkg::S_IDLE;
          end
          lmqb_pkg::OP_NOP: state_nxt = lmqb_pkg::S_IDLE;
          default: begin
            if (sts.out_free) state_nxt = lmqb_pkg::S_IDLE;
          end
        endcase
      end
      lmqb_pkg::S_DUMP: begin
        if (sts.out_free && sts.final_elem) state_nxt = lmqb_pkg::S_IDLE;
      end
      default: state_nxt = lmqb_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.status     = lmqb_pkg::ST_ELEM;
    unique case (state_r)
      lmqb_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      lmqb_pkg::S_EXEC: begin
        unique case (sts.op)
          lmqb_pkg::OP_PUSH: begin
            cmd.emit = sts.out_free;
            cmd.last = 1'b1;
            if (!sts.q_ok || sts.pool_empty) begin
              cmd.status = lmqb_pkg::ST_FULL;
            end else begin
              cmd.status = lmqb_pkg::ST_PUSHED;
              cmd.push   = sts.out_free;
            end
          end
          lmqb_pkg::OP_DUMP: begin
            if (sts.q_live) begin
              cmd.dump_start = 1'b1;
            end else begin
              cmd.emit   = sts.out_free;
              cmd.status = lmqb_pkg::ST_EMPTY;
              cmd.last   = 1'b1;
            end
          end
          lmqb_pkg::OP_CLEAR: begin
            cmd.emit   = sts.out_free;
            cmd.status = lmqb_pkg::ST_CLEARED;
            cmd.last   = 1'b1;
            cmd.clear  = sts.out_free && sts.q_live;
          end
          default: ;
        endcase
      end
      lmqb_pkg::S_DUMP: begin
        cmd.status = lmqb_pkg::ST_ELEM;
        cmd.last   = sts.final_elem;
        cmd.emit   = sts.out_free;
        // on a stall the datapath re-reads the current entry
        cmd.dump_next = sts.out_free && !sts.final_elem;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/lmqb_dp.sv
// ----------------------------------------------------------------------------
// lmqb_dp
// Datapath: queue table, link and data memories, free chain, output register.
// ----------------------------------------------------------------------------
module lmqb_dp #(
  parameter int NUM_QUEUES   = 16,
  parameter int POOL_ENTRIES = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  lmqb_pkg::in_t  in_data,
  input  lmqb_pkg::cmd_t cmd,
  output lmqb_pkg::sts_t sts,
  output logic           out_valid,
  input  logic           out_ready,
  output lmqb_pkg::out_t out_data
);

  localparam int PW = $clog2(POOL_ENTRIES);
  localparam int CW = $clog2(POOL_ENTRIES + 1);
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int QE = 2 * PW + CW;

  // memories
  logic [QE-1:0] qtab_mem [NUM_QUEUES];    // {head, tail, count}
  logic [PW-1:0] link_mem [POOL_ENTRIES];
  logic [31:0]   data_mem [POOL_ENTRIES];

  logic [NUM_QUEUES-1:0]   nonempty_r;
  logic [POOL_ENTRIES-1:0] link_vld_r;     // clear = reset free chain value

  lmqb_pkg::op_t      op_r;
  logic [QW-1:0]      q_r, q_nxt;
  logic               q_ok_r;
  logic signed [31:0] value_r;
  logic [PW-1:0]      free_head_r, free_tail_r;
  logic [CW-1:0]      free_cnt_r;
  logic [PW-1:0]      rd_addr_r, rd_addr_nxt;
  logic [PW-1:0]      link_q_r;
  logic               link_vld_q_r;
  logic [31:0]        data_q_r;
  logic [QE-1:0]      qent_q_r;
  logic [CW-1:0]      rem_r;
  logic               out_valid_r;
  lmqb_pkg::out_t     out_data_r, out_data_nxt;

  logic [PW-1:0] q_head, q_tail, link_rd, link_wa, link_wd;
  logic [CW-1:0] q_cnt;
  logic          q_live, link_we, out_free;
  logic [QE-1:0] qent_wd;

  assign {q_head, q_tail, q_cnt} = qent_q_r;
  assign q_live   = q_ok_r && nonempty_r[q_r];
  assign out_free = !out_valid_r || out_ready;

  // entry never linked since reset still holds its free chain successor
  assign link_rd = link_vld_q_r ? link_q_r :
                   (rd_addr_r == PW'(POOL_ENTRIES - 1)) ? '0 : rd_addr_r + PW'(1);

  assign q_nxt = cmd.load ? QW'(in_data.queue_sel) : q_r;

  always_comb begin
    if (cmd.load)            rd_addr_nxt = free_head_r;
    else if (cmd.dump_start) rd_addr_nxt = q_head;
    else if (cmd.dump_next)  rd_addr_nxt = link_rd;
    else                     rd_addr_nxt = rd_addr_r;
  end

  always_comb begin
    link_we = 1'b0;
    link_wa = q_tail;
    link_wd = free_head_r;
    if (cmd.push && q_live) begin
      link_we = 1'b1;
    end else if (cmd.clear && free_cnt_r != '0) begin
      link_we = 1'b1;
      link_wa = free_tail_r;
      link_wd = q_head;
    end
  end

  assign qent_wd = q_live ? {q_head, free_head_r, q_cnt + CW'(1)}
                          : {free_head_r, free_head_r, CW'(1)};

  always_ff @(posedge clk) begin
    link_q_r     <= link_mem[rd_addr_nxt];
    data_q_r     <= data_mem[rd_addr_nxt];
    qent_q_r     <= qtab_mem[q_nxt];
    link_vld_q_r <= link_vld_r[rd_addr_nxt];
    if (link_we) link_mem[link_wa] <= link_wd;
    if (cmd.push) begin
      data_mem[free_head_r] <= value_r;
      qtab_mem[q_r]         <= qent_wd;
    end
  end

  // item payload and walk registers
  always_ff @(posedge clk) begin
    q_r       <= q_nxt;
    rd_addr_r <= rd_addr_nxt;
    if (cmd.load) begin
      op_r    <= lmqb_pkg::op_t'(in_data.op);
      q_ok_r  <= 32'(in_data.queue_sel) < 32'(NUM_QUEUES);
      value_r <= in_data.value;
    end
    if (cmd.dump_start)     rem_r <= q_cnt;
    else if (cmd.dump_next) rem_r <= rem_r - CW'(1);
  end

  // free chain and queue flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= '0;
      free_tail_r <= PW'(POOL_ENTRIES - 1);
      free_cnt_r  <= CW'(POOL_ENTRIES);
      nonempty_r  <= '0;
      link_vld_r  <= '0;
    end else begin
      if (link_we) link_vld_r[link_wa] <= 1'b1;
      if (cmd.push) begin
        free_head_r   <= link_rd;
        free_cnt_r    <= free_cnt_r - CW'(1);
        nonempty_r[q_r] <= 1'b1;
      end else if (cmd.clear) begin
        if (free_cnt_r == '0) free_head_r <= q_head;
        free_tail_r     <= q_tail;
        free_cnt_r      <= free_cnt_r + q_cnt;
        nonempty_r[q_r] <= 1'b0;
      end
    end
  end

  // output register
  always_comb begin
    out_data_nxt.status     = cmd.status;
    out_data_nxt.elem_value = (cmd.status == lmqb_pkg::ST_ELEM) ? data_q_r : '0;
    out_data_nxt.last       = cmd.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.op         = op_r;
  assign sts.q_ok       = q_ok_r;
  assign sts.q_live     = q_live;
  assign sts.pool_empty = (free_cnt_r == '0);
  assign sts.final_elem = (rem_r == CW'(1));
  assign sts.out_free   = out_free;

endmodule

// File: rtl/linked_multi_queue_buffer_top.sv
// ----------------------------------------------------------------------------
// linked_multi_queue_buffer_top
// Queues sharing one linked entry pool: push, dump, clear.
//
//   channel  ports                       payload
//   input    in_valid / in_ready         in_data  {op, queue_sel, value}
//   result   out_valid / out_ready       out_data {status, elem_value, last}
//
// One item at a time. Push and clear read the queue table and link memory,
// then update. A dump steps through accept, head lookup, then each element
// in turn, read through the single read port of the link memory. Op code 3
// gives no result. Reset is synchronous; no clearing pass. A stalled result
// holds the sequencer in place.
// ----------------------------------------------------------------------------
module linked_multi_queue_buffer_top #(
  parameter int NUM_QUEUES   = 16,
  parameter int POOL_ENTRIES = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  lmqb_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output lmqb_pkg::out_t out_data
);

  lmqb_pkg::cmd_t cmd;
  lmqb_pkg::sts_t sts;

  lmqb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lmqb_dp #(
    .NUM_QUEUES   (NUM_QUEUES),
    .POOL_ENTRIES (POOL_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
